@@ rtl/sgcc_pkg.sv @@
// Shared types and constants of the segment grid collision checker.
package sgcc_pkg;

	// Operation codes of a request.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// Verdict codes of a result.
	localparam logic [1:0] VERDICT_OK        = 2'd0;
	localparam logic [1:0] VERDICT_TOO_SHORT = 2'd1;
	localparam logic [1:0] VERDICT_TOO_LONG  = 2'd2;
	localparam logic [1:0] VERDICT_HIT       = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_MIN_DISTANCE = 2'd2;
	localparam logic [1:0] REG_MAX_DISTANCE = 2'd3;

	// Sample spacing of 10 units in Q8.
	localparam logic [16:0] STEP_Q8 = 17'd2560;

	typedef struct packed {
		logic        op;
		logic [11:0] start_x;
		logic [11:0] start_y;
		logic [11:0] end_x;
		logic [11:0] end_y;
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic        cell_blocked;
	} request_t;

	typedef struct packed {
		logic       connected;
		logic [1:0] verdict;
	} result_t;

endpackage

@@ rtl/sgcc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sgcc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/sgcc_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module sgcc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] value,
	output logic        done,
	output logic [15:0] root
);
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [31:0] val_q;
	logic [3:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [17:0] rem_n;
	logic [17:0] trial;

	// One restoring step: bring down two bits and try the next root bit.
	always_comb begin
		rem_n = {rem_q[15:0], val_q[31:30]};
		trial = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath needs no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= value;
		end else if (run_q) begin
			val_q <= {val_q[29:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

@@ rtl/sgcc_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, eight-bit quotient.
module sgcc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [7:0]  quot,
	output logic        rem_nz
);
	logic [23:0] rem_q;
	logic [15:0] den_q;
	logic [7:0]  quot_q;
	logic [2:0]  bit_q;
	logic        run_q;
	logic        done_q;
	logic [23:0] trial;

	// Divisor aligned to the quotient bit under test.
	assign trial = 24'(den_q) << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				bit_q <= 3'd7;
			end else if (run_q) begin
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q          <= rem_q - trial;
				quot_q[bit_q]  <= 1'b1;
			end
		end
	end

	assign done   = done_q;
	assign quot   = quot_q;
	assign rem_nz = (rem_q != '0);
endmodule

@@ rtl/segment_grid_collision_check.sv @@
// Top level of the segment collision checker against a one-bit obstacle grid.
//
//  Channel   Signals                          Handshake
//  --------  -------------------------------  ------------------------------
//  request   start, busy, request             taken when start & !busy
//  result    result_valid, result             one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_wdata     written when cfg_we is high
//
// A cell write keeps the block busy in the single ST_WRITE state after the request is taken.
// A check rejected by the range test passes through ST_SQ and ST_CMP and strobes its
// result as the block returns to idle. Otherwise squares, range test and square root
// (16 iterations) come first, then each sample runs the two eight-step divisions and
// the grid read (the read is skipped off the map), and a closing ST_SAMP ends the check.
// Reset clears control and config registers only; the grid memory is not cleared,
// and the result strobe cannot be held off, so the block never stalls on output.
module segment_grid_collision_check #(
	parameter int GRID_COLS   = 256,
	parameter int GRID_ROWS   = 256,
	parameter int MAX_SAMPLES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sgcc_pkg::request_t request,
	output logic              result_valid,
	output sgcc_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [8:0]        cfg_wdata
);
	import sgcc_pkg::*;

	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_SAMPLES + 1);
	localparam logic [AW-1:0] COLS_A = AW'(GRID_COLS);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WRITE = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_CMP   = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_SAMP  = 4'd5;
	localparam logic [3:0] ST_DIVX  = 4'd6;
	localparam logic [3:0] ST_DIVY  = 4'd7;
	localparam logic [3:0] ST_ADDR  = 4'd8;
	localparam logic [3:0] ST_READ  = 4'd9;

	logic [3:0]         state_q;
	request_t           req_q;
	logic [8:0]         map_width_q, map_height_q;
	logic [7:0]         min_dist_q, max_dist_q;
	logic signed [12:0] dx_q, dy_q;
	logic [25:0]        dx2_q, dy2_q;
	logic [15:0]        min2_q, max2_q;
	logic [25:0]        d2_q;
	logic [15:0]        dist_q;
	logic [IW-1:0]      idx_q;
	logic [16:0]        acc_q;
	logic [23:0]        px_s1, py_s1;
	logic signed [8:0]  qx_q, qy_q;
	logic               sqrt_go_q, div_go_q;
	logic               res_valid_q;
	result_t            res_q;

	logic [25:0]        d2;
	logic [11:0]        adx, ady;
	logic               sqrt_done, div_done, div_nz;
	logic [15:0]        sqrt_root;
	logic [7:0]         div_quot;
	logic signed [8:0]  q_signed;
	logic               div_neg;
	logic signed [13:0] sx, sy;
	logic               skip;
	logic               ram_we, ram_re, ram_rdata;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic               last_sample;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= 9'd256;
			map_height_q <= 9'd256;
			min_dist_q   <= 8'd10;
			max_dist_q   <= 8'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_WIDTH:    map_width_q  <= cfg_wdata;
				REG_MAP_HEIGHT:   map_height_q <= cfg_wdata;
				REG_MIN_DISTANCE: min_dist_q   <= cfg_wdata[7:0];
				REG_MAX_DISTANCE: max_dist_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Magnitudes of the deltas; the sampling path only runs with both at most 255.
	assign adx = dx_q[12] ? 12'(-dx_q) : 12'(dx_q);
	assign ady = dy_q[12] ? 12'(-dy_q) : 12'(dy_q);
	assign d2  = dx2_q + dy2_q;
	assign last_sample = (idx_q == IW'(MAX_SAMPLES)) ||
		((acc_q + STEP_Q8) > 17'(dist_q));

	// Floor of the signed quotient from the unsigned division.
	assign div_neg  = (state_q == ST_DIVX) ? dx_q[12] : dy_q[12];
	assign q_signed = div_neg ? -(9'(div_quot) + 9'(div_nz)) : 9'(div_quot);

	// Sample point and map bounds.
	assign sx   = 14'(req_q.start_x) + 14'(qx_q);
	assign sy   = 14'(req_q.start_y) + 14'(qy_q);
	assign skip = sx[13] || sy[13] ||
		(unsigned'(sx) >= 14'(map_width_q)) || (unsigned'(sy) >= 14'(map_height_q)) ||
		(unsigned'(sx) >= 14'(GRID_COLS)) || (unsigned'(sy) >= 14'(GRID_ROWS));

	// Grid memory ports.
	assign ram_we    = (state_q == ST_WRITE) &&
		(13'(req_q.cell_x) < 13'(GRID_COLS)) && (13'(req_q.cell_y) < 13'(GRID_ROWS));
	assign ram_waddr = AW'(req_q.cell_y) * COLS_A + AW'(req_q.cell_x);
	assign ram_re    = (state_q == ST_ADDR) && !skip;
	assign ram_raddr = AW'(unsigned'(sy)) * COLS_A + AW'(unsigned'(sx));

	sgcc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req_q.cell_blocked),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sgcc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_go_q),
		.value  ({1'b0, d2_q[14:0], 16'd0}),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	sgcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    ((state_q == ST_DIVX) ? px_s1 : py_s1),
		.den    (dist_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem_nz (div_nz)
	);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sqrt_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			sqrt_go_q   <= 1'b0;
			div_go_q    <= 1'b0;
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= (request.op == OP_WRITE) ? ST_WRITE : ST_SQ;
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_SQ:    state_q <= ST_CMP;
				ST_CMP: begin
					if (d2 < 26'(min2_q) || d2 > 26'(max2_q)) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						sqrt_go_q <= 1'b1;
						state_q   <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						idx_q   <= '0;
						state_q <= ST_SAMP;
					end
				end
				ST_SAMP: begin
					if (last_sample) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (skip) begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_SAMP;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (ram_rdata) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_SAMP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= request;
				dx_q  <= 13'(request.end_x) - 13'(request.start_x);
				dy_q  <= 13'(request.end_y) - 13'(request.start_y);
			end
			ST_SQ: begin
				dx2_q  <= 26'(adx) * 26'(adx);
				dy2_q  <= 26'(ady) * 26'(ady);
				min2_q <= min_dist_q * min_dist_q;
				max2_q <= max_dist_q * max_dist_q;
			end
			ST_CMP: begin
				d2_q <= d2;
				if (d2 < 26'(min2_q)) begin
					res_q <= '{connected: 1'b0, verdict: VERDICT_TOO_SHORT};
				end else begin
					res_q <= '{connected: 1'b0, verdict: VERDICT_TOO_LONG};
				end
			end
			ST_SQRT: begin
				dist_q <= sqrt_root;
				acc_q  <= '0;
			end
			ST_SAMP: begin
				px_s1 <= 24'(adx[7:0]) * 24'(acc_q);
				py_s1 <= 24'(ady[7:0]) * 24'(acc_q);
				res_q <= '{connected: 1'b1, verdict: VERDICT_OK};
			end
			ST_DIVX: begin
				if (div_done) qx_q <= q_signed;
			end
			ST_DIVY: begin
				if (div_done) qy_q <= q_signed;
			end
			ST_ADDR: begin
				if (skip) acc_q <= acc_q + STEP_Q8;
			end
			ST_READ: begin
				acc_q <= acc_q + STEP_Q8;
				res_q <= '{connected: 1'b0, verdict: VERDICT_HIT};
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// A result only closes a check that was in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a check in flight");

	// The connected flag agrees with the verdict code.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.connected == (result.verdict == VERDICT_OK)))
		else $error("connected flag disagrees with verdict");

	// An accepted request always occupies the block for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start work");

	// The sample index never runs past the sample limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IW'(MAX_SAMPLES))
		else $error("sample index beyond limit");
endmodule
